// ===== hdl/sexpr_lexer_nesting_check_core_assert.svh =====
// Assertion macros for the S-expression tokenizer core.
`ifndef SEXPR_LEXER_NESTING_CHECK_CORE_ASSERT_SVH
`define SEXPR_LEXER_NESTING_CHECK_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SXLNC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SXLNC_ASSERT_NEVER(label, cond, msg) \
   `SXLNC_ASSERT(label, !(cond), msg)

`endif

// ===== hdl/sxlnc_pkg.sv =====
// Shared types, constants and helper functions for the S-expression tokenizer.
`default_nettype none

package sxlnc_pkg;

   // Defaults for the top level parameters
   localparam int MAX_DEPTH_DEFAULT = 255;
   localparam int POS_WIDTH_DEFAULT = 16;

   // Result word field widths
   localparam int FIELD_W     = 16;
   localparam int NEST_W      = 8;
   localparam logic [FIELD_W-1:0] LEN_MAX = '1;

   // Result queue depth, a power of two of at least 2
   localparam int RSP_FIFO_DEPTH = 4;

   // Characters
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_END  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_NUMBER = 3'd1,
      MODE_SYMBOL = 3'd2,
      MODE_MINUS  = 3'd3,
      MODE_ERROR  = 3'd4
   } lex_mode_type;

   typedef enum logic [2:0] {
      KIND_LPAREN = 3'd0,
      KIND_RPAREN = 3'd1,
      KIND_NUMBER = 3'd2,
      KIND_SYMBOL = 3'd3,
      KIND_END    = 3'd4,
      KIND_ERROR  = 3'd5
   } token_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_MISSING    = 2'd1,
      ERR_UNEXPECTED = 2'd2,
      ERR_DEPTH      = 2'd3
   } error_code_type;

   typedef struct packed {
      token_kind_type       token_kind;
      error_code_type       error_code;
      logic [FIELD_W-1:0]   start_line;
      logic [FIELD_W-1:0]   start_column;
      logic [FIELD_W-1:0]   token_length;
      logic [NEST_W-1:0]    nest_depth;
      logic                 last_of_run;
   } rsp_item_type;

   // Up to two result words per accepted input word, in order
   typedef struct packed {
      logic         wr0;
      logic         wr1;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_push_type;

   typedef struct packed {
      logic not_empty;
      logic has_room;
   } fifo_status_type;

   function automatic logic is_ws(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic [FIELD_W-1:0] sat_field(input logic [31:0] v);
      return (v > 32'(LEN_MAX)) ? LEN_MAX : v[FIELD_W-1:0];
   endfunction

   function automatic logic [NEST_W-1:0] sat_nest(input logic [31:0] v);
      logic [NEST_W-1:0] lim;
      lim = '1;
      return (v > 32'(lim)) ? lim : v[NEST_W-1:0];
   endfunction

   function automatic rsp_item_type make_item(
      input token_kind_type     kind,
      input error_code_type     err,
      input logic [31:0]        ln,
      input logic [31:0]        col,
      input logic [FIELD_W-1:0] len,
      input logic [31:0]        depth
   );
      rsp_item_type r;
      r.token_kind   = kind;
      r.error_code   = err;
      r.start_line   = sat_field(ln);
      r.start_column = sat_field(col);
      r.token_length = len;
      r.nest_depth   = sat_nest(depth);
      r.last_of_run  = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/sxlnc_lexer.sv =====
// Lexer state registers and combinational next-state and result logic.
`default_nettype none

module sxlnc_lexer #(
   parameter int MAX_DEPTH = sxlnc_pkg::MAX_DEPTH_DEFAULT,
   parameter int POS_WIDTH = sxlnc_pkg::POS_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  word_take,
   input  logic                  cmd,
   input  logic [7:0]            text_byte,
   output sxlnc_pkg::rsp_push_type push
);

   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam logic [DEPTH_W-1:0]   DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);
   localparam logic [DEPTH_W-1:0]   DEPTH_ONE   = DEPTH_W'(1);
   localparam logic [POS_WIDTH-1:0] POS_MAX     = '1;
   localparam logic [POS_WIDTH-1:0] POS_ONE     = POS_WIDTH'(1);
   localparam logic [sxlnc_pkg::FIELD_W-1:0] LEN_ONE = sxlnc_pkg::FIELD_W'(1);
   localparam logic [sxlnc_pkg::FIELD_W-1:0] LEN_TWO = sxlnc_pkg::FIELD_W'(2);

   sxlnc_pkg::lex_mode_type          mode_ff, mode_in;
   logic [POS_WIDTH-1:0]             line_ff, line_in;
   logic [POS_WIDTH-1:0]             col_ff, col_in;
   logic [POS_WIDTH-1:0]             tsl_ff, tsl_in;
   logic [POS_WIDTH-1:0]             tsc_ff, tsc_in;
   logic [sxlnc_pkg::FIELD_W-1:0]    plen_ff, plen_in;
   logic [DEPTH_W-1:0]               depth_ff, depth_in;

   logic [POS_WIDTH-1:0]             step_line, step_col;
   logic [sxlnc_pkg::FIELD_W-1:0]    plen_inc;
   logic                             b_digit, b_ws, b_delim;
   logic                             flush, fresh, b_valid;
   sxlnc_pkg::rsp_item_type          item_a, item_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= sxlnc_pkg::MODE_IDLE;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         tsl_ff   <= POS_ONE;
         tsc_ff   <= POS_ONE;
         plen_ff  <= '0;
         depth_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         tsl_ff   <= tsl_in;
         tsc_ff   <= tsc_in;
         plen_ff  <= plen_in;
         depth_ff <= depth_in;
      end
   end

   // Position after this byte; a pending flush never moves it
   always_comb begin
      if (text_byte == sxlnc_pkg::CH_NEWLINE) begin
         step_line = (line_ff < POS_MAX) ? line_ff + POS_ONE : line_ff;
         step_col  = POS_ONE;
      end else begin
         step_line = line_ff;
         step_col  = (col_ff < POS_MAX) ? col_ff + POS_ONE : col_ff;
      end
   end

   assign plen_inc = (plen_ff != sxlnc_pkg::LEN_MAX) ? plen_ff + LEN_ONE : plen_ff;
   assign b_digit  = sxlnc_pkg::is_digit(text_byte);
   assign b_ws     = sxlnc_pkg::is_ws(text_byte);
   assign b_delim  = b_ws || (text_byte == sxlnc_pkg::CH_LPAREN) ||
                     (text_byte == sxlnc_pkg::CH_RPAREN);

   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      tsl_in   = tsl_ff;
      tsc_in   = tsc_ff;
      plen_in  = plen_ff;
      depth_in = depth_ff;
      flush    = 1'b0;
      fresh    = 1'b0;
      b_valid  = 1'b0;
      item_a   = sxlnc_pkg::make_item(
                    (mode_ff == sxlnc_pkg::MODE_NUMBER) ? sxlnc_pkg::KIND_NUMBER
                                                        : sxlnc_pkg::KIND_SYMBOL,
                    sxlnc_pkg::ERR_NONE, 32'(tsl_ff), 32'(tsc_ff), plen_ff,
                    32'(depth_ff));
      item_b   = sxlnc_pkg::make_item(sxlnc_pkg::KIND_END, sxlnc_pkg::ERR_NONE,
                    32'(line_ff), 32'(col_ff), '0, 32'(depth_ff));

      if (word_take) begin
         if (cmd == sxlnc_pkg::CMD_END) begin
            // End of stream: flush, report, then return to the reset state
            b_valid = 1'b1;
            if (mode_ff != sxlnc_pkg::MODE_ERROR) begin
               flush = (mode_ff != sxlnc_pkg::MODE_IDLE);
               if (depth_ff != '0) begin
                  item_b = sxlnc_pkg::make_item(sxlnc_pkg::KIND_ERROR,
                              sxlnc_pkg::ERR_MISSING, 32'(line_ff), 32'(col_ff), '0,
                              32'(depth_ff));
               end
            end
            mode_in  = sxlnc_pkg::MODE_IDLE;
            line_in  = POS_ONE;
            col_in   = POS_ONE;
            tsl_in   = POS_ONE;
            tsc_in   = POS_ONE;
            plen_in  = '0;
            depth_in = '0;
         end else begin
            unique case (mode_ff)
               sxlnc_pkg::MODE_ERROR: begin
               end
               sxlnc_pkg::MODE_IDLE: begin
                  fresh = 1'b1;
               end
               sxlnc_pkg::MODE_MINUS: begin
                  if (b_digit) begin
                     mode_in = sxlnc_pkg::MODE_NUMBER;
                     plen_in = LEN_TWO;
                     line_in = step_line;
                     col_in  = step_col;
                  end else if (b_delim) begin
                     flush = 1'b1;
                     fresh = 1'b1;
                  end else begin
                     mode_in = sxlnc_pkg::MODE_SYMBOL;
                     plen_in = plen_inc;
                     line_in = step_line;
                     col_in  = step_col;
                  end
               end
               sxlnc_pkg::MODE_SYMBOL: begin
                  if (b_delim) begin
                     flush = 1'b1;
                     fresh = 1'b1;
                  end else begin
                     plen_in = plen_inc;
                     line_in = step_line;
                     col_in  = step_col;
                  end
               end
               sxlnc_pkg::MODE_NUMBER: begin
                  if (b_digit) begin
                     plen_in = plen_inc;
                     line_in = step_line;
                     col_in  = step_col;
                  end else begin
                     flush = 1'b1;
                     fresh = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            // Start on this byte with no token pending
            if (fresh) begin
               mode_in = sxlnc_pkg::MODE_IDLE;
               priority if (b_ws) begin
                  line_in = step_line;
                  col_in  = step_col;
               end else if (text_byte == sxlnc_pkg::CH_LPAREN) begin
                  b_valid = 1'b1;
                  if (depth_ff >= DEPTH_LIMIT) begin
                     mode_in = sxlnc_pkg::MODE_ERROR;
                     item_b  = sxlnc_pkg::make_item(sxlnc_pkg::KIND_ERROR,
                                  sxlnc_pkg::ERR_DEPTH, 32'(line_ff), 32'(col_ff), '0,
                                  32'(depth_ff));
                  end else begin
                     depth_in = depth_ff + DEPTH_ONE;
                     item_b   = sxlnc_pkg::make_item(sxlnc_pkg::KIND_LPAREN,
                                   sxlnc_pkg::ERR_NONE, 32'(line_ff), 32'(col_ff), '0,
                                   32'(depth_ff + DEPTH_ONE));
                     line_in  = step_line;
                     col_in   = step_col;
                  end
               end else if (text_byte == sxlnc_pkg::CH_RPAREN) begin
                  b_valid = 1'b1;
                  if (depth_ff == '0) begin
                     mode_in = sxlnc_pkg::MODE_ERROR;
                     item_b  = sxlnc_pkg::make_item(sxlnc_pkg::KIND_ERROR,
                                  sxlnc_pkg::ERR_UNEXPECTED, 32'(line_ff), 32'(col_ff),
                                  '0, 32'(depth_ff));
                  end else begin
                     depth_in = depth_ff - DEPTH_ONE;
                     item_b   = sxlnc_pkg::make_item(sxlnc_pkg::KIND_RPAREN,
                                   sxlnc_pkg::ERR_NONE, 32'(line_ff), 32'(col_ff), '0,
                                   32'(depth_ff - DEPTH_ONE));
                     line_in  = step_line;
                     col_in   = step_col;
                  end
               end else begin
                  tsl_in  = line_ff;
                  tsc_in  = col_ff;
                  plen_in = LEN_ONE;
                  line_in = step_line;
                  col_in  = step_col;
                  if (b_digit) begin
                     mode_in = sxlnc_pkg::MODE_NUMBER;
                  end else if (text_byte == sxlnc_pkg::CH_MINUS) begin
                     mode_in = sxlnc_pkg::MODE_MINUS;
                  end else begin
                     mode_in = sxlnc_pkg::MODE_SYMBOL;
                  end
               end
            end
         end
      end

      // Pack results in order: flushed token first
      push.wr0   = flush || b_valid;
      push.wr1   = flush && b_valid;
      push.item0 = flush ? item_a : item_b;
      push.item0.last_of_run = !(flush && b_valid);
      push.item1 = item_b;
      push.item1.last_of_run = 1'b1;
   end

endmodule

`default_nettype wire

// ===== hdl/sxlnc_rsp_fifo.sv =====
// Result queue taking up to two words per cycle and giving one.
`default_nettype none

module sxlnc_rsp_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  sxlnc_pkg::rsp_push_type     push,
   input  logic                        pop,
   output sxlnc_pkg::rsp_item_type     head,
   output sxlnc_pkg::fifo_status_type  status
);

   localparam int DEPTH = sxlnc_pkg::RSP_FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sxlnc_pkg::rsp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.wr0) + PTR_W'(push.wr1);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.wr0) + CNT_W'(push.wr1) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.wr0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.wr1) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.item1;
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   // Room for the worst case of two words from one input word
   assign status.has_room  = (count_ff <= CNT_W'(DEPTH - 2));

endmodule

`default_nettype wire

// ===== hdl/sexpr_lexer_nesting_check_core.sv =====
// Top level of the S-expression tokenizer with nesting check.
//
//   channel | ports                              | direction | word
//   --------+------------------------------------+-----------+-----------------------------
//   req     | req_valid/req_ready, req_cmd, ...  | in        | one text byte or end mark
//   rsp     | rsp_valid/rsp_ready, rsp_token_... | out       | one token, end or error
//
// When an input word is taken, the lexer state updates and its zero, one or
// two result words land in a four-entry result queue on the same edge; when
// the queue was empty, the first of them shows on rsp the next cycle.
// A word is taken whenever the queue has room for two results, so with the
// result side ready the block takes one word every cycle while words yield at
// most one result; words that yield two results fill the queue faster than
// its single read port drains it, and a burst of them drops req_ready once
// the queue holds three words.
// Reset is synchronous and active high; it returns the lexer to line 1,
// column 1, depth 0, and empties the queue. A stall on rsp fills the queue to
// three words or more and so drops req_ready until a slot pair frees.
`default_nettype none

module sexpr_lexer_nesting_check_core #(
   parameter int MAX_DEPTH = sxlnc_pkg::MAX_DEPTH_DEFAULT,
   parameter int POS_WIDTH = sxlnc_pkg::POS_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_text_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_token_kind,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_start_line,
   output logic [15:0] rsp_start_column,
   output logic [15:0] rsp_token_length,
   output logic [7:0]  rsp_nest_depth,
   output logic        rsp_last_of_run
);

`include "sexpr_lexer_nesting_check_core_assert.svh"

   sxlnc_pkg::rsp_push_type    push;
   sxlnc_pkg::rsp_item_type    head;
   sxlnc_pkg::fifo_status_type fifo_status;
   logic                       req_take;
   logic                       rsp_take;

   // Take a word only when both possible results fit
   assign req_ready = fifo_status.has_room;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = fifo_status.not_empty;
   assign rsp_take  = rsp_valid && rsp_ready;

   sxlnc_lexer #(
      .MAX_DEPTH (MAX_DEPTH),
      .POS_WIDTH (POS_WIDTH)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .word_take (req_take),
      .cmd       (req_cmd),
      .text_byte (req_text_byte),
      .push      (push)
   );

   sxlnc_rsp_fifo u_rsp_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (rsp_take),
      .head   (head),
      .status (fifo_status)
   );

   // Unpack the head of the queue onto the result ports
   assign rsp_token_kind   = head.token_kind;
   assign rsp_error_code   = head.error_code;
   assign rsp_start_line   = head.start_line;
   assign rsp_start_column = head.start_column;
   assign rsp_token_length = head.token_length;
   assign rsp_nest_depth   = head.nest_depth;
   assign rsp_last_of_run  = head.last_of_run;

   // An empty queue always has room for the next input word
   `SXLNC_ASSERT_NEVER(a_empty_blocks_req, !rsp_valid && !req_ready, "req stalled with empty queue")

   // Error kind and nonzero error code always travel together
   `SXLNC_ASSERT(a_err_code_match, rsp_valid |-> ((rsp_token_kind == sxlnc_pkg::KIND_ERROR) == (rsp_error_code != sxlnc_pkg::ERR_NONE)), "error code does not match kind")

   // End results and missing-paren errors close the run of their input word
   `SXLNC_ASSERT(a_end_is_last, (rsp_valid && (rsp_token_kind == sxlnc_pkg::KIND_END || rsp_error_code == sxlnc_pkg::ERR_MISSING)) |-> rsp_last_of_run, "end result not last of run")

   // A taken word that yields a result shows a valid result next cycle
   `SXLNC_ASSERT(a_push_shows, (push.wr0) |=> rsp_valid, "pushed result not visible")

endmodule

`default_nettype wire
